// ----- hw/rtl/ufs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Disjoint-set engine package
// Shared widths, memory port types and the sequencer state type.
// ----------------------------------------------------------------------------
package ufs_pkg;

  localparam int unsigned IdxW     = 10;
  localparam int unsigned CntW     = 11;
  localparam int unsigned MaxNodes = 1024;

  localparam logic [CntW-1:0] CntReset = CntW'(MaxNodes);
  localparam logic [CntW-1:0] CntMax   = CntW'(MaxNodes);

  localparam logic KindFind  = 1'b0;
  localparam logic KindUnion = 1'b1;

  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] addr;
    logic [IdxW-1:0] data;
  } ufs_pwr_t;

  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] addr;
    logic [CntW-1:0] data;
  } ufs_swr_t;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StWalk,
    StComp,
    StSizeA,
    StSizeB,
    StDone
  } ufs_state_e;

endpackage

// ----- hw/rtl/ufs_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Disjoint-set tables
// Parent and size memories, each with one write port and one registered read.
// ----------------------------------------------------------------------------
module ufs_mem (
  input  logic                  clk_i,
  input  logic [ufs_pkg::IdxW-1:0] p_raddr_i,
  output logic [ufs_pkg::IdxW-1:0] p_rdata_o,
  input  ufs_pkg::ufs_pwr_t     p_wr_i,
  input  logic [ufs_pkg::IdxW-1:0] s_raddr_i,
  output logic [ufs_pkg::CntW-1:0] s_rdata_o,
  input  ufs_pkg::ufs_swr_t     s_wr_i
);
  import ufs_pkg::*;

  logic [IdxW-1:0] parent_mem [MaxNodes];
  logic [CntW-1:0] size_mem   [MaxNodes];

  always_ff @(posedge clk_i) begin
    if (p_wr_i.we) begin
      parent_mem[p_wr_i.addr] <= p_wr_i.data;
    end
    p_rdata_o <= parent_mem[p_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (s_wr_i.we) begin
      size_mem[s_wr_i.addr] <= s_wr_i.data;
    end
    s_rdata_o <= size_mem[s_raddr_i];
  end

endmodule

// ----- hw/rtl/union_find_by_size_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Disjoint-set engine, union by size with path compression
// A request word carries kind, node_a and node_b and is taken when in_valid_i
// is high and in_stall_o is low. kind 0 finds the root of node_a, kind 1
// joins the sets of node_a and node_b. One result word follows each request
// on the output channel and is taken when out_valid_o is high and out_stall_i
// is low; a stalled result holds, and the next request is still accepted.
// The node_count register is written through cfg_valid_i/cfg_ready_o; write it
// only while the block is idle, which the block itself does not enforce.
// A request walks from node_a up to its root, one parent read a cycle, then
// walks the path again and rewrites each link to point at the root. A union
// does the same for node_b, then reads both set sizes and links the root of
// the smaller set under the other, or leaves the sets as they are when both
// roots match. Out-of-range requests skip the walk and go to the result.
// The next request is taken in the cycle after the result enters the output
// register; while a full output register is stalled, a finished result waits.
// After reset the block sweeps both tables, one entry a cycle, and holds
// in_stall_o high during that sweep.
// ----------------------------------------------------------------------------
module union_find_by_size_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [ufs_pkg::CntW-1:0]  cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      kind_i,
  input  logic [ufs_pkg::IdxW-1:0]  node_a_i,
  input  logic [ufs_pkg::IdxW-1:0]  node_b_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [ufs_pkg::IdxW-1:0]  root_a_o,
  output logic [ufs_pkg::IdxW-1:0]  root_b_o,
  output logic                      already_joined_o,
  output logic [ufs_pkg::CntW-1:0]  set_size_o,
  output logic                      out_of_range_o
);
  import ufs_pkg::*;

  ufs_state_e state_q, state_d;

  logic [CntW-1:0] count_q;
  logic [IdxW-1:0] clr_q, clr_d;
  logic            kind_q, kind_d;
  logic            phase_q, phase_d;
  logic [IdxW-1:0] b_q, b_d;
  logic [IdxW-1:0] node_q, node_d;
  logic [IdxW-1:0] cur_q, cur_d;
  logic [IdxW-1:0] root_q, root_d;
  logic [IdxW-1:0] ra_q, ra_d;
  logic [IdxW-1:0] rb_q, rb_d;
  logic [CntW-1:0] sza_q, sza_d;

  logic [IdxW-1:0] res_ra_q, res_ra_d;
  logic [IdxW-1:0] res_rb_q, res_rb_d;
  logic            res_j_q, res_j_d;
  logic [CntW-1:0] res_sz_q, res_sz_d;
  logic            res_oor_q, res_oor_d;

  logic            out_valid_q, out_valid_d;
  logic            out_load;

  logic [IdxW-1:0] p_raddr;
  logic [IdxW-1:0] p_rdata;
  ufs_pwr_t        p_wr;
  logic [IdxW-1:0] s_raddr;
  logic [CntW-1:0] s_rdata;
  ufs_swr_t        s_wr;

  logic [CntW-1:0] eff_cnt;
  logic            req_oor;
  logic [CntW-1:0] size_sum;

  ufs_mem u_mem (
    .clk_i     (clk_i),
    .p_raddr_i (p_raddr),
    .p_rdata_o (p_rdata),
    .p_wr_i    (p_wr),
    .s_raddr_i (s_raddr),
    .s_rdata_o (s_rdata),
    .s_wr_i    (s_wr)
  );

  assign eff_cnt  = (count_q > CntMax) ? CntMax : count_q;
  assign req_oor  = ({1'b0, node_a_i} >= eff_cnt) ||
                    ((kind_i == KindUnion) && ({1'b0, node_b_i} >= eff_cnt));
  assign size_sum = sza_q + s_rdata;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != StIdle);
  assign out_load    = (state_q == StDone) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StClear: begin
        if (clr_q == {IdxW{1'b1}}) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (in_valid_i) begin
          state_d = req_oor ? StDone : StWalk;
        end
      end
      StWalk: begin
        if (p_rdata == cur_q) begin
          state_d = StComp;
        end
      end
      StComp: begin
        if (cur_q == root_q) begin
          if (kind_q == KindUnion && !phase_q) begin
            state_d = StWalk;
          end else begin
            state_d = StSizeA;
          end
        end
      end
      StSizeA: begin
        if (kind_q == KindFind || ra_q == rb_q) begin
          state_d = StDone;
        end else begin
          state_d = StSizeB;
        end
      end
      StSizeB: state_d = StDone;
      StDone: begin
        if (out_load) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    clr_d     = clr_q;
    kind_d    = kind_q;
    phase_d   = phase_q;
    b_d       = b_q;
    node_d    = node_q;
    cur_d     = cur_q;
    root_d    = root_q;
    ra_d      = ra_q;
    rb_d      = rb_q;
    sza_d     = sza_q;
    res_ra_d  = res_ra_q;
    res_rb_d  = res_rb_q;
    res_j_d   = res_j_q;
    res_sz_d  = res_sz_q;
    res_oor_d = res_oor_q;
    p_raddr   = cur_q;
    s_raddr   = ra_q;
    p_wr      = '0;
    s_wr      = '0;
    unique case (state_q)
      StClear: begin
        p_wr  = '{we: 1'b1, addr: clr_q, data: clr_q};
        s_wr  = '{we: 1'b1, addr: clr_q, data: CntW'(1)};
        clr_d = clr_q + IdxW'(1);
      end
      StIdle: begin
        kind_d    = kind_i;
        b_d       = node_b_i;
        node_d    = node_a_i;
        cur_d     = node_a_i;
        phase_d   = 1'b0;
        p_raddr   = node_a_i;
        res_ra_d  = '0;
        res_rb_d  = '0;
        res_j_d   = 1'b0;
        res_sz_d  = '0;
        res_oor_d = req_oor;
      end
      StWalk: begin
        if (p_rdata == cur_q) begin
          root_d  = cur_q;
          cur_d   = node_q;
          p_raddr = node_q;
        end else begin
          cur_d   = p_rdata;
          p_raddr = p_rdata;
        end
      end
      StComp: begin
        if (cur_q == root_q) begin
          if (!phase_q) begin
            ra_d    = root_q;
            s_raddr = root_q;
            phase_d = 1'b1;
            node_d  = b_q;
            cur_d   = b_q;
            p_raddr = b_q;
          end else begin
            rb_d    = root_q;
            s_raddr = ra_q;
          end
        end else begin
          p_wr    = '{we: 1'b1, addr: cur_q, data: root_q};
          cur_d   = p_rdata;
          p_raddr = p_rdata;
        end
      end
      StSizeA: begin
        res_ra_d = ra_q;
        res_sz_d = s_rdata;
        if (kind_q == KindUnion) begin
          res_rb_d = rb_q;
          res_j_d  = (ra_q == rb_q);
        end
        sza_d   = s_rdata;
        s_raddr = rb_q;
      end
      StSizeB: begin
        res_sz_d = size_sum;
        if (sza_q < s_rdata) begin
          p_wr     = '{we: 1'b1, addr: ra_q, data: rb_q};
          s_wr     = '{we: 1'b1, addr: rb_q, data: size_sum};
          res_ra_d = rb_q;
        end else begin
          p_wr     = '{we: 1'b1, addr: rb_q, data: ra_q};
          s_wr     = '{we: 1'b1, addr: ra_q, data: size_sum};
          res_ra_d = ra_q;
        end
      end
      StDone: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_q       <= '0;
      count_q     <= CntReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        count_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q    <= kind_d;
    phase_q   <= phase_d;
    b_q       <= b_d;
    node_q    <= node_d;
    cur_q     <= cur_d;
    root_q    <= root_d;
    ra_q      <= ra_d;
    rb_q      <= rb_d;
    sza_q     <= sza_d;
    res_ra_q  <= res_ra_d;
    res_rb_q  <= res_rb_d;
    res_j_q   <= res_j_d;
    res_sz_q  <= res_sz_d;
    res_oor_q <= res_oor_d;
    if (out_load) begin
      root_a_o         <= res_ra_q;
      root_b_o         <= res_rb_q;
      already_joined_o <= res_j_q;
      set_size_o       <= res_sz_q;
      out_of_range_o   <= res_oor_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- test/union_find_by_size_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Disjoint-set engine testbench
// Drives find and union request words in random bursts, with long and short
// output stalls, and checks every result word against a behavioral disjoint-set
// predictor that keeps its own parent and size tables. The node count register
// is rewritten between phases while the engine is idle.
// ----------------------------------------------------------------------------
module union_find_by_size_core_tb;
  import ufs_pkg::*;

  typedef struct packed {
    logic            kind;
    logic [IdxW-1:0] node_a;
    logic [IdxW-1:0] node_b;
  } request_t;

  typedef struct packed {
    logic [IdxW-1:0] root_a;
    logic [IdxW-1:0] root_b;
    logic            joined;
    logic [CntW-1:0] size;
    logic            oor;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CntW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic kind_i = 1'b0;
  logic [IdxW-1:0] node_a_i = '0;
  logic [IdxW-1:0] node_b_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [IdxW-1:0] root_a_o;
  logic [IdxW-1:0] root_b_o;
  logic already_joined_o;
  logic [CntW-1:0] set_size_o;
  logic out_of_range_o;

  union_find_by_size_core uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  request_t pending_reqs[$];
  answer_t  expected_answers[$];
  logic [IdxW-1:0] parent_links[MaxNodes];
  logic [CntW-1:0] set_sizes[MaxNodes];
  logic [CntW-1:0] node_limit;
  int mismatches = 0;
  int accepted_reqs = 0;

  function automatic logic [IdxW-1:0] seek_root(input logic [IdxW-1:0] n);
    logic [IdxW-1:0] r;
    logic [IdxW-1:0] cur;
    logic [IdxW-1:0] nxt;
    int g;
    r = n;
    g = 0;
    while (parent_links[r] != r && g < MaxNodes) begin
      r = parent_links[r];
      g++;
    end
    cur = n;
    g = 0;
    while (cur != r && g < MaxNodes) begin
      nxt = parent_links[cur];
      parent_links[cur] = r;
      cur = nxt;
      g++;
    end
    return r;
  endfunction

  function automatic answer_t apply_request(input request_t q);
    answer_t ans;
    int lim;
    logic [IdxW-1:0] ra;
    logic [IdxW-1:0] rb;
    ans = '0;
    lim = (node_limit > CntMax) ? CntMax : node_limit;
    if (q.node_a >= lim || (q.kind == KindUnion && q.node_b >= lim)) begin
      ans.oor = 1'b1;
    end else if (q.kind == KindFind) begin
      ans.root_a = seek_root(q.node_a);
      ans.size = set_sizes[ans.root_a];
    end else begin
      ra = seek_root(q.node_a);
      rb = seek_root(q.node_b);
      ans.root_b = rb;
      if (ra == rb) begin
        ans.joined = 1'b1;
        ans.root_a = ra;
        ans.size = set_sizes[ra];
      end else if (set_sizes[ra] < set_sizes[rb]) begin
        parent_links[ra] = rb;
        set_sizes[rb] = set_sizes[rb] + set_sizes[ra];
        ans.root_a = rb;
        ans.size = set_sizes[rb];
      end else begin
        parent_links[rb] = ra;
        set_sizes[ra] = set_sizes[ra] + set_sizes[rb];
        ans.root_a = ra;
        ans.size = set_sizes[ra];
      end
    end
    return ans;
  endfunction

  task automatic note_failure(input string what, input answer_t exp_a, input answer_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t %s: expected ra=%0d rb=%0d j=%0b sz=%0d oor=%0b",
               $realtime, what, exp_a.root_a, exp_a.root_b, exp_a.joined, exp_a.size,
               exp_a.oor);
      $display("    got ra=%0d rb=%0d j=%0b sz=%0d oor=%0b",
               got.root_a, got.root_b, got.joined, got.size, got.oor);
    end
  endtask

  // Monitor: predicts on each accepted request and checks each accepted result.
  always @(posedge clk_i) begin
    request_t q;
    answer_t got;
    answer_t exp_a;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        node_limit <= cfg_data_i;
      end
      if (in_valid_i && !in_stall_o) begin
        q = '{kind: kind_i, node_a: node_a_i, node_b: node_b_i};
        exp_a = apply_request(q);
        expected_answers = {expected_answers, exp_a};
        accepted_reqs++;
      end
      if (out_valid_o && !out_stall_i) begin
        got = '{root_a: root_a_o, root_b: root_b_o, joined: already_joined_o,
                size: set_size_o, oor: out_of_range_o};
        if (expected_answers.size() == 0) begin
          note_failure("unexpected result word", '0, got);
        end else begin
          exp_a = expected_answers.pop_front();
          if (got !== exp_a) begin
            note_failure("result mismatch", exp_a, got);
          end
        end
      end
    end
  end

  // A request word still waiting after the last rising edge.
  logic in_wait = 1'b0;
  always @(posedge clk_i) begin
    in_wait <= in_valid_i && in_stall_o;
  end

  // Driver: sends request words in bursts separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk_i) begin
    request_t q;
    if (rst_ni && !in_wait) begin
      if (burst_left > 0 && pending_reqs.size() > 0) begin
        q = pending_reqs.pop_front();
        in_valid_i <= 1'b1;
        kind_i <= q.kind;
        node_a_i <= q.node_a;
        node_b_i <= q.node_b;
        burst_left <= burst_left - 1;
      end else begin
        in_valid_i <= 1'b0;
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else begin
          burst_left <= $urandom_range(1, 20);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
        end
      end
    end
  end

  // Receiver: stalls in changing modes, with one long hold-off.
  int stall_mode = 0;
  int mode_cycles = 0;
  int hold_left = 0;
  bit long_hold_done = 1'b0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!long_hold_done && accepted_reqs >= 100) begin
        long_hold_done <= 1'b1;
        hold_left <= 400;
        out_stall_i <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall_i <= 1'b1;
      end else begin
        if (mode_cycles == 0) begin
          stall_mode <= $urandom_range(0, 2);
          mode_cycles <= $urandom_range(10, 80);
        end else begin
          mode_cycles <= mode_cycles - 1;
        end
        case (stall_mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 3) == 0);
          default: out_stall_i <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  task automatic add_req(input logic kind, input int a, input int b);
    request_t r;
    r = '{kind: kind, node_a: a[IdxW-1:0], node_b: b[IdxW-1:0]};
    pending_reqs = {pending_reqs, r};
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() > 0 || in_valid_i || expected_answers.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (5) @(posedge clk_i);
  endtask

  task automatic write_count(input int value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value[CntW-1:0];
    @(posedge clk_i);
    while (!cfg_ready_o) begin
      @(posedge clk_i);
    end
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic add_random(input int n, input int lim);
    int span;
    int a;
    int b;
    span = (lim > MaxNodes) ? MaxNodes : lim;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0 || span == 0) begin
        a = $urandom_range(0, MaxNodes - 1);
        b = $urandom_range(0, MaxNodes - 1);
      end else begin
        a = $urandom_range(0, span - 1);
        b = $urandom_range(0, span - 1);
      end
      add_req($urandom_range(0, 2) != 0 ? KindUnion : KindFind, a, b);
    end
  endtask

  initial begin
    node_limit = CntReset;
    for (int i = 0; i < MaxNodes; i++) begin
      parent_links[i] = i[IdxW-1:0];
      set_sizes[i] = 1;
    end
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    add_req(KindFind, 0, 1023);
    add_req(KindFind, 1023, 0);
    add_req(KindUnion, 0, 1023);
    add_req(KindUnion, 1023, 0);
    add_req(KindUnion, 1, 2);
    add_req(KindUnion, 3, 1);
    add_req(KindUnion, 0, 3);
    add_req(KindUnion, 4, 5);
    add_req(KindUnion, 6, 4);
    add_req(KindUnion, 4, 0);
    add_req(KindFind, 5, 682);
    add_req(KindFind, 5, 341);
    add_req(KindFind, 1023, 0);
    wait_idle();
    write_count(0);
    add_req(KindFind, 0, 0);
    add_req(KindUnion, 0, 0);
    wait_idle();
    write_count(2047);
    add_req(KindUnion, 1023, 512);
    add_req(KindFind, 512, 0);
    wait_idle();
    write_count(16);
    add_req(KindFind, 15, 1023);
    add_req(KindFind, 16, 0);
    add_req(KindUnion, 5, 16);
    add_req(KindUnion, 16, 5);
    add_req(KindFind, 0, 0);
    add_req(KindUnion, 15, 14);
    wait_idle();

    write_count(1024);
    add_random(130, 1024);
    wait_idle();
    write_count(64);
    add_random(110, 64);
    wait_idle();
    write_count(1);
    add_random(20, 1);
    wait_idle();
    write_count(8);
    add_random(100, 8);
    wait_idle();
    write_count(2047);
    add_random(100, 1024);
    wait_idle();
    write_count(300);
    add_random(80, 300);
    wait_idle();
    repeat (50) @(posedge clk_i);

    if (expected_answers.size() > 0) begin
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/ufs_pkg.sv
hw/rtl/ufs_mem.sv
hw/rtl/union_find_by_size_core.sv
test/union_find_by_size_core_tb.sv
